@@ sv/deq_pkg.sv @@
package deq_pkg;

  localparam int DEQ_CAPACITY = 1024;

  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int COUNT_W = 11;

  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;

  localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic take_rdata;
    logic load_out;
  } deq_cmd_t;

  typedef struct packed {
    logic need_read;
  } deq_stat_t;

endpackage

@@ sv/double_ended_queue_unit.sv @@
// Sequence: latch input, execute (S_EXEC), refill read (S_READ, only for
//   a pop that leaves at least one element), load output (S_LOAD, held
//   until the output register is free). Input stalls until the load; the
//   single memory port with registered read data sets the refill step.
// Reset: synchronous, active low; queue empty, no output pending.
//   Element memory is not cleared; only written entries are ever read.
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int CAPACITY = DEQ_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [WORD_W-1:0]  in_push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [WORD_W-1:0]  out_popped_value,
  output logic signed [WORD_W-1:0]  out_front_value,
  output logic signed [WORD_W-1:0]  out_back_value,
  output logic [COUNT_W-1:0]        out_element_count,
  output logic                      out_is_empty,
  output logic                      out_push_dropped
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_push_value     (in_push_value),
    .out_popped_value  (out_popped_value),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_push_dropped  (out_push_dropped)
  );

endmodule

@@ sv/deq_datapath.sv @@
module deq_datapath import deq_pkg::*; #(
  parameter int CAPACITY = DEQ_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  deq_cmd_t                  cmd,
  output deq_stat_t                 stat,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [WORD_W-1:0]  in_push_value,
  output logic signed [WORD_W-1:0]  out_popped_value,
  output logic signed [WORD_W-1:0]  out_front_value,
  output logic signed [WORD_W-1:0]  out_back_value,
  output logic [COUNT_W-1:0]        out_element_count,
  output logic                      out_is_empty,
  output logic                      out_push_dropped
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  logic signed [WORD_W-1:0] mem [CAPACITY];
  logic signed [WORD_W-1:0] rdata_r;

  logic [FUNC_W-1:0]        op_r;
  logic signed [WORD_W-1:0] val_r;
  logic [IW-1:0]            head_r, head_nxt;
  logic [IW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] front_r, back_r;
  logic signed [WORD_W-1:0] popped_r;
  logic                     dropped_r;
  logic                     rd_front_r;

  logic                     full, is_push;
  logic                     do_pf, do_pb, do_popf, do_popb;
  logic                     mem_we;
  logic [IW-1:0]            mem_addr;
  logic [CW+COUNT_W-1:0]    count_wide;

  assign full    = (count_r == FULL_CNT);
  assign is_push = (op_r == OP_PUSH_FRONT) || (op_r == OP_PUSH_BACK);
  assign do_pf   = (op_r == OP_PUSH_FRONT) && !full;
  assign do_pb   = (op_r == OP_PUSH_BACK) && !full;
  assign do_popf = (op_r == OP_POP_FRONT) && (count_r != '0);
  assign do_popb = (op_r == OP_POP_BACK) && (count_r != '0);

  // head/tail move first; the memory address is the moved index whenever one moves
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    priority if (do_pf) begin
      head_nxt  = idx_dec(head_r);
      count_nxt = count_r + 1'b1;
    end else if (do_pb) begin
      tail_nxt  = idx_inc(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (do_popf) begin
      head_nxt  = idx_inc(head_r);
      count_nxt = count_r - 1'b1;
    end else if (do_popb) begin
      tail_nxt  = idx_dec(tail_r);
      count_nxt = count_r - 1'b1;
    end
  end

  assign mem_we   = cmd.exec && (do_pf || do_pb);
  assign mem_addr = (do_pf || do_popf) ? head_nxt : tail_nxt;
  assign stat.need_read = (do_popf || do_popb) && (count_r > CW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= val_r;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= LAST_IDX;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_func;
      val_r <= in_push_value;
    end
    if (cmd.exec) begin
      popped_r   <= do_popf ? front_r : (do_popb ? back_r : EMPTY_VALUE);
      dropped_r  <= is_push && full;
      rd_front_r <= do_popf;
      if (do_pf) begin
        front_r <= val_r;
        if (count_r == '0) begin
          back_r <= val_r;
        end
      end else if (do_pb) begin
        back_r <= val_r;
        if (count_r == '0) begin
          front_r <= val_r;
        end
      end
    end
    // refill the cached end that a pop just exposed
    if (cmd.take_rdata) begin
      if (rd_front_r) begin
        front_r <= rdata_r;
      end else begin
        back_r <= rdata_r;
      end
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped_value  <= popped_r;
      out_front_value   <= (count_r == '0) ? EMPTY_VALUE : front_r;
      out_back_value    <= (count_r == '0) ? EMPTY_VALUE : back_r;
      out_element_count <= count_wide[COUNT_W-1:0];
      out_is_empty      <= (count_r == '0);
      out_push_dropped  <= dropped_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("element count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (do_pf || do_pb) |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the count");

  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> tail_r == idx_dec(head_r))
    else $error("head and tail disagree on an empty queue");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && is_push && full |=> count_r == $past(count_r) && head_r == $past(head_r)
      && tail_r == $past(tail_r))
    else $error("dropped push changed the queue");

endmodule

@@ sv/deq_ctrl.sv @@
module deq_ctrl import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = accept;
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_read ? S_READ : S_LOAD;
      end
      S_READ: begin
        cmd.take_rdata = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted transaction not executed");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && stat.need_read |=> state_r == S_READ)
    else $error("pop refill read skipped");

  a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD && !out_free |=> state_r == S_LOAD && out_valid_r)
    else $error("result loaded over an untaken transaction");

endmodule
